// ----- src/cfr_pkg.sv -----
// ---------------------------------------------------------------------------
// Command frame receiver package
// Shared types, codes and character constants of the frame receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

   // default sizes of the two field stores
   localparam int DIGIT_DEPTH_DEF = 9;
   localparam int NAME_DEPTH_DEF  = 16;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_START_CHAR  = 2'd0,
      REG_END_CHAR    = 2'd1,
      REG_RX_TIMEOUT  = 2'd2,
      REG_ERR_TIMEOUT = 2'd3
   } reg_index_type;

   localparam logic [7:0]  START_CHAR_RST  = 8'd36;
   localparam logic [7:0]  END_CHAR_RST    = 8'd35;
   localparam logic [15:0] RX_TIMEOUT_RST  = 16'd1000;
   localparam logic [15:0] ERR_TIMEOUT_RST = 16'd1000;

   typedef struct packed {
      logic [7:0]  open_byte;
      logic [7:0]  close_byte;
      logic [15:0] rx_timeout_ticks;
      logic [15:0] err_timeout_ticks;
   } cfg_type;

   // input word kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_WAIT_START = 3'd0,
      ST_COMMAND    = 3'd1,
      ST_DATA       = 3'd2,
      ST_NAME       = 3'd3,
      ST_WAIT_END   = 3'd4,
      ST_ERROR      = 3'd5
   } frame_state_type;

   // characters of the frame syntax
   localparam logic [7:0] CH_CMD_START = 8'h31;  // '1'
   localparam logic [7:0] CH_CMD_STOP  = 8'h32;  // '2'
   localparam logic [7:0] CH_DATA_END  = 8'h25;  // '%'
   localparam logic [7:0] CH_NAME_END  = 8'h26;  // '&'
   localparam logic [7:0] CH_ZERO      = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE      = 8'h39;  // '9'
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_Z   = 8'h7A;

   // two decimal digits to a value, kept to 7 bits
   function automatic logic [6:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
      logic [7:0] sum;
      sum = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
      return sum[6:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/cfr_req_if.sv -----
// ---------------------------------------------------------------------------
// Request channel
// Carries one received byte or timer tick per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;

   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- src/cfr_rsp_if.sv -----
// ---------------------------------------------------------------------------
// Response channel
// Carries the receiver status after each request word.
// ---------------------------------------------------------------------------
`default_nettype none

interface cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] rx_state;
   logic       running;
   logic       tx_enable;
   logic [6:0] temp_min;
   logic [6:0] temp_max;
   logic [6:0] soil_humidity;
   logic [6:0] air_humidity;
   logic [3:0] supply_code;
   logic [4:0] name_length;

   modport source (output valid, output rx_state, output running, output tx_enable,
                   output temp_min, output temp_max, output soil_humidity,
                   output air_humidity, output supply_code, output name_length,
                   input ready);
   modport sink   (input valid, input rx_state, input running, input tx_enable,
                   input temp_min, input temp_max, input soil_humidity,
                   input air_humidity, input supply_code, input name_length,
                   output ready);
endinterface

`default_nettype wire

// ----- src/cfr_csr.sv -----
// ---------------------------------------------------------------------------
// Frame receiver register bank
// APB-style configuration registers: start/end characters and timeouts.
// ---------------------------------------------------------------------------
`default_nettype none

module cfr_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cfr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cfr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cfr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output cfr_pkg::cfg_type                    cfg
);

   cfr_pkg::cfg_type      cfg_ff;
   cfr_pkg::cfg_type      cfg_in;
   cfr_pkg::reg_index_type sel;
   logic                  wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign sel    = cfr_pkg::reg_index_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            cfr_pkg::REG_START_CHAR:  cfg_in.open_byte         = pwdata[7:0];
            cfr_pkg::REG_END_CHAR:    cfg_in.close_byte        = pwdata[7:0];
            cfr_pkg::REG_RX_TIMEOUT:  cfg_in.rx_timeout_ticks  = pwdata[15:0];
            cfr_pkg::REG_ERR_TIMEOUT: cfg_in.err_timeout_ticks = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_byte         <= cfr_pkg::START_CHAR_RST;
         cfg_ff.close_byte        <= cfr_pkg::END_CHAR_RST;
         cfg_ff.rx_timeout_ticks  <= cfr_pkg::RX_TIMEOUT_RST;
         cfg_ff.err_timeout_ticks <= cfr_pkg::ERR_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (sel)
         cfr_pkg::REG_START_CHAR:  prdata = {24'd0, cfg_ff.open_byte};
         cfr_pkg::REG_END_CHAR:    prdata = {24'd0, cfg_ff.close_byte};
         cfr_pkg::REG_RX_TIMEOUT:  prdata = {16'd0, cfg_ff.rx_timeout_ticks};
         cfr_pkg::REG_ERR_TIMEOUT: prdata = {16'd0, cfg_ff.err_timeout_ticks};
         default:                  prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/cfr_core.sv -----
// ---------------------------------------------------------------------------
// Frame receiver core
// Input register, frame state update and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module cfr_core #(
   parameter int DIGIT_DEPTH = cfr_pkg::DIGIT_DEPTH_DEF,
   parameter int NAME_DEPTH  = cfr_pkg::NAME_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfr_pkg::cfg_type cfg,
   cfr_req_if.sink               req,
   cfr_rsp_if.source             rsp
);

   localparam int MAX_DEPTH = (DIGIT_DEPTH > NAME_DEPTH) ? DIGIT_DEPTH : NAME_DEPTH;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int LEN_W     = (CNT_W > 5) ? CNT_W : 5;

   // input register
   logic       in_valid_ff;
   logic       in_op_ff;
   logic [7:0] in_byte_ff;

   // frame state
   cfr_pkg::frame_state_type state_ff, state_in;
   logic [3:0]       digit_ff [DIGIT_DEPTH];
   logic [3:0]       digit_in [DIGIT_DEPTH];
   logic [CNT_W-1:0] field_count_ff, field_count_in;
   logic [LEN_W-1:0] name_count_ff, name_count_in;
   logic             start_flag_ff, start_flag_in;
   logic             stop_flag_ff, stop_flag_in;
   logic             running_ff, running_in;
   logic             tx_flag_ff, tx_flag_in;
   logic [15:0]      byte_timer_ff, byte_timer_in;
   logic [15:0]      error_timer_ff, error_timer_in;

   // result register
   logic             out_valid_ff;
   logic [2:0]       out_state_ff;
   logic             out_running_ff;
   logic             out_tx_ff;
   logic [6:0]       out_tmin_ff, out_tmax_ff, out_soil_ff, out_air_ff;
   logic [3:0]       out_supply_ff;
   logic [4:0]       out_len_ff;

   logic advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      logic [7:0] b;
      logic       is_digit;
      logic       is_letter;
      logic [15:0] bt_next;
      logic [15:0] et_next;

      b         = in_byte_ff;
      is_digit  = b inside {[cfr_pkg::CH_ZERO:cfr_pkg::CH_NINE]};
      is_letter = b inside {[cfr_pkg::CH_UPPER_A:cfr_pkg::CH_UPPER_Z],
                            [cfr_pkg::CH_LOWER_A:cfr_pkg::CH_LOWER_Z]};
      bt_next   = byte_timer_ff + 16'd1;
      et_next   = error_timer_ff + 16'd1;

      state_in       = state_ff;
      digit_in       = digit_ff;
      field_count_in = field_count_ff;
      name_count_in  = name_count_ff;
      start_flag_in  = start_flag_ff;
      stop_flag_in   = stop_flag_ff;
      running_in     = running_ff;
      tx_flag_in     = tx_flag_ff;
      byte_timer_in  = byte_timer_ff;
      error_timer_in = error_timer_ff;

      if (advance) begin
         if (in_op_ff == cfr_pkg::OP_TICK) begin
            if (state_ff == cfr_pkg::ST_DATA || state_ff == cfr_pkg::ST_NAME) begin
               byte_timer_in = bt_next;
               if (bt_next >= cfg.rx_timeout_ticks) begin
                  state_in       = cfr_pkg::ST_ERROR;
                  error_timer_in = '0;
               end
            end else if (state_ff == cfr_pkg::ST_ERROR) begin
               error_timer_in = et_next;
               if (et_next >= cfg.err_timeout_ticks) begin
                  error_timer_in = '0;
                  state_in       = cfr_pkg::ST_WAIT_START;
               end
            end
         end else begin
            case (state_ff)
               cfr_pkg::ST_WAIT_START: begin
                  if (b == cfg.open_byte) begin
                     field_count_in = '0;
                     name_count_in  = '0;
                     byte_timer_in  = '0;
                     state_in       = cfr_pkg::ST_COMMAND;
                  end else begin
                     state_in       = cfr_pkg::ST_ERROR;
                     error_timer_in = '0;
                  end
               end
               cfr_pkg::ST_COMMAND: begin
                  if (b == cfr_pkg::CH_CMD_START) begin
                     start_flag_in = 1'b1;
                     stop_flag_in  = 1'b0;
                     tx_flag_in    = 1'b1;
                     byte_timer_in = '0;
                     state_in      = cfr_pkg::ST_DATA;
                  end else if (b == cfr_pkg::CH_CMD_STOP) begin
                     start_flag_in = 1'b0;
                     stop_flag_in  = 1'b1;
                     tx_flag_in    = 1'b0;
                     byte_timer_in = '0;
                     state_in      = cfr_pkg::ST_WAIT_END;
                  end else begin
                     state_in       = cfr_pkg::ST_ERROR;
                     error_timer_in = '0;
                  end
               end
               cfr_pkg::ST_DATA: begin
                  if (is_digit) begin
                     byte_timer_in = '0;
                     if (field_count_ff < CNT_W'(DIGIT_DEPTH)) begin
                        for (int i = 0; i < DIGIT_DEPTH; i++) begin
                           if (field_count_ff == CNT_W'(i)) begin
                              digit_in[i] = b[3:0];  // '0' sits at 0x30
                           end
                        end
                        field_count_in = field_count_ff + CNT_W'(1);
                     end
                  end else if (b == cfr_pkg::CH_DATA_END) begin
                     byte_timer_in  = '0;
                     field_count_in = '0;
                     state_in       = cfr_pkg::ST_NAME;
                  end else begin
                     state_in       = cfr_pkg::ST_ERROR;
                     error_timer_in = '0;
                  end
               end
               cfr_pkg::ST_NAME: begin
                  // name characters are not kept: only their count shows
                  if (is_letter) begin
                     byte_timer_in = '0;
                     if (field_count_ff < CNT_W'(NAME_DEPTH - 1)) begin
                        field_count_in = field_count_ff + CNT_W'(1);
                     end
                  end else if (b == cfr_pkg::CH_NAME_END) begin
                     byte_timer_in  = '0;
                     name_count_in  = LEN_W'(field_count_ff) + LEN_W'(1);
                     field_count_in = '0;
                     state_in       = cfr_pkg::ST_WAIT_END;
                  end else begin
                     state_in       = cfr_pkg::ST_ERROR;
                     error_timer_in = '0;
                  end
               end
               cfr_pkg::ST_WAIT_END: begin
                  if (b == cfg.close_byte) begin
                     if (start_flag_ff) begin
                        running_in   = 1'b1;
                        stop_flag_in = 1'b0;
                     end else if (stop_flag_ff) begin
                        running_in    = 1'b0;
                        start_flag_in = 1'b0;
                     end
                     state_in = cfr_pkg::ST_WAIT_START;
                  end else begin
                     state_in       = cfr_pkg::ST_ERROR;
                     error_timer_in = '0;
                  end
               end
               default: ;  // bytes are ignored in the error state
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff       <= cfr_pkg::ST_WAIT_START;
         field_count_ff <= '0;
         name_count_ff  <= '0;
         start_flag_ff  <= 1'b0;
         stop_flag_ff   <= 1'b1;
         running_ff     <= 1'b0;
         tx_flag_ff     <= 1'b0;
         byte_timer_ff  <= '0;
         error_timer_ff <= '0;
         for (int i = 0; i < DIGIT_DEPTH; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         if (req.valid && req.ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         state_ff       <= state_in;
         digit_ff       <= digit_in;
         field_count_ff <= field_count_in;
         name_count_ff  <= name_count_in;
         start_flag_ff  <= start_flag_in;
         stop_flag_ff   <= stop_flag_in;
         running_ff     <= running_in;
         tx_flag_ff     <= tx_flag_in;
         byte_timer_ff  <= byte_timer_in;
         error_timer_ff <= error_timer_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_op_ff   <= req.op;
         in_byte_ff <= req.rx_byte;
      end
      if (advance) begin
         out_state_ff   <= state_in;
         out_running_ff <= running_in;
         out_tx_ff      <= tx_flag_in;
         out_tmin_ff    <= cfr_pkg::pair_value(digit_in[0], digit_in[1]);
         out_tmax_ff    <= cfr_pkg::pair_value(digit_in[2], digit_in[3]);
         out_soil_ff    <= cfr_pkg::pair_value(digit_in[4], digit_in[5]);
         out_air_ff     <= cfr_pkg::pair_value(digit_in[6], digit_in[7]);
         out_supply_ff  <= digit_in[8];
         out_len_ff     <= name_count_in[4:0];
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.rx_state      = out_state_ff;
   assign rsp.running       = out_running_ff;
   assign rsp.tx_enable     = out_tx_ff;
   assign rsp.temp_min      = out_tmin_ff;
   assign rsp.temp_max      = out_tmax_ff;
   assign rsp.soil_humidity = out_soil_ff;
   assign rsp.air_humidity  = out_air_ff;
   assign rsp.supply_code   = out_supply_ff;
   assign rsp.name_length   = out_len_ff;

   // an item in the input register moves on to the result register
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word did not reach result register");

   // input is only blocked by a full pipe whose result is not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (in_valid_ff && out_valid_ff && !rsp.ready))
      else $error("input stalled without cause");

   // error timer only runs inside the error state
   a_err_timer_idle: assert property (@(posedge clock) disable iff (reset)
      (error_timer_ff != 16'd0) |-> (state_ff == cfr_pkg::ST_ERROR))
      else $error("error timer left non-zero outside error state");

   // field counter bounds per stage
   a_field_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == cfr_pkg::ST_DATA) |-> (field_count_ff <= CNT_W'(DIGIT_DEPTH))) and
      ((state_ff == cfr_pkg::ST_NAME) |-> (field_count_ff <= CNT_W'(NAME_DEPTH - 1))))
      else $error("field counter out of range");

endmodule

`default_nettype wire

// ----- src/command_frame_receiver.sv -----
// ---------------------------------------------------------------------------
// Command frame receiver
// Decodes serial command frames, byte by byte, with tick-driven timeouts.
// ---------------------------------------------------------------------------
// Usage:
//  - req_port: one word per byte or timer tick (op 0 = byte in rx_byte,
//    op 1 = tick). rsp_port: one status word per request word, in order,
//    holding state, flags, decoded two-digit values, supply digit and name length.
//  - APB registers at 0x0 start char, 0x4 end char, 0x8 byte timeout,
//    0xC error timeout. Write them only while no word is in flight.
//  - Path: an accepted word passes the input register, then the state update
//    and the result register, which holds its status word.
//  - Throughput: one word per cycle while rsp_port is not stalled, set by the
//    combinational state update between the two registers.
//  - Reset (synchronous): waits for a start char, stop flag set, others
//    and digits clear, registers take defaults; no clearing sweep needed.
//  - When rsp_port is stalled the result register holds and the input
//    register can still take one more word; after that req_port.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module command_frame_receiver #(
   parameter int DIGIT_DEPTH = cfr_pkg::DIGIT_DEPTH_DEF,
   parameter int NAME_DEPTH  = cfr_pkg::NAME_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   cfr_req_if.sink                             req_port,
   cfr_rsp_if.source                           rsp_port,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [cfr_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [cfr_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [cfr_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);

   // live config; user, not block, keeps it stable while words are in flight
   cfr_pkg::cfg_type cfg;

   cfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // frame decoder: input register, state update, result register
   cfr_core #(
      .DIGIT_DEPTH (DIGIT_DEPTH),
      .NAME_DEPTH  (NAME_DEPTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_port),
      .rsp   (rsp_port)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Command frame receiver testbench
// Feeds bytes and timer ticks through the request channel and holds its own
// model of the frame decoder. Each status word on the response channel is
// checked field by field against the model. Both channels idle and stall at
// random, and the APB registers are rewritten between phases while the
// block is quiet.
// ---------------------------------------------------------------------------

module tb;
   import cfr_pkg::*;

   localparam int DIGIT_DEPTH = DIGIT_DEPTH_DEF;
   localparam int NAME_DEPTH  = NAME_DEPTH_DEF;
   localparam int IDLE_LIMIT  = 2000;   // cycles with no handshake at all
   localparam int MAX_PRINTED = 100;

   // ------------------------------------------------------------------------
   // Clock, reset and the block
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   cfr_req_if req_bus ();
   cfr_rsp_if rsp_bus ();

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   command_frame_receiver u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // channel inputs known from time zero
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.op      = OP_BYTE;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Frame decoder model
   // ------------------------------------------------------------------------
   typedef struct packed {
      frame_state_type rx_state;
      logic            running;
      logic            tx_enable;
      logic [6:0]      temp_min;
      logic [6:0]      temp_max;
      logic [6:0]      soil_humidity;
      logic [6:0]      air_humidity;
      logic [3:0]      supply_code;
      logic [4:0]      name_length;
   } status_type;

   logic [7:0]  cfg_open_byte;
   logic [7:0]  cfg_close_byte;
   logic [15:0] cfg_rx_ticks;
   logic [15:0] cfg_err_ticks;

   frame_state_type rcv_state;
   logic [3:0]      rcv_digits [DIGIT_DEPTH];
   int              rcv_field;
   int              rcv_name_len;
   int              rcv_byte_tmr;
   int              rcv_err_tmr;
   bit              rcv_start;
   bit              rcv_stop;
   bit              rcv_running;
   bit              rcv_tx;

   function automatic void reset_receiver();
      cfg_open_byte  = START_CHAR_RST;
      cfg_close_byte = END_CHAR_RST;
      cfg_rx_ticks   = RX_TIMEOUT_RST;
      cfg_err_ticks  = ERR_TIMEOUT_RST;
      rcv_state      = ST_WAIT_START;
      foreach (rcv_digits[i]) rcv_digits[i] = 4'd0;
      rcv_field      = 0;
      rcv_name_len   = 0;
      rcv_byte_tmr   = 0;
      rcv_err_tmr    = 0;
      rcv_start      = 1'b0;
      rcv_stop       = 1'b1;
      rcv_running    = 1'b0;
      rcv_tx         = 1'b0;
   endfunction

   function automatic void to_error();
      rcv_state   = ST_ERROR;
      rcv_err_tmr = 0;
   endfunction

   function automatic logic [6:0] digit_pair(input int first);
      return 7'(rcv_digits[first] * 10 + rcv_digits[first + 1]);
   endfunction

   // one word in, the status word it must produce out
   function automatic status_type step_receiver(input logic op, input logic [7:0] b);
      status_type s;
      bit         is_digit;
      bit         is_letter;
      is_digit  = (b >= CH_ZERO && b <= CH_NINE);
      is_letter = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
                  (b >= CH_LOWER_A && b <= CH_LOWER_Z);
      if (op == OP_TICK) begin
         // ticks only matter while a field is open or while in error
         if (rcv_state == ST_DATA || rcv_state == ST_NAME) begin
            rcv_byte_tmr++;
            if (rcv_byte_tmr >= cfg_rx_ticks) to_error();
         end else if (rcv_state == ST_ERROR) begin
            rcv_err_tmr++;
            if (rcv_err_tmr >= cfg_err_ticks) begin
               rcv_err_tmr = 0;
               rcv_state   = ST_WAIT_START;
            end
         end
      end else begin
         case (rcv_state)
            ST_WAIT_START: begin
               if (b == cfg_open_byte) begin
                  rcv_field    = 0;
                  rcv_name_len = 0;
                  rcv_byte_tmr = 0;
                  rcv_state    = ST_COMMAND;
               end else begin
                  to_error();
               end
            end
            ST_COMMAND: begin
               if (b == CH_CMD_START) begin
                  rcv_start    = 1'b1;
                  rcv_stop     = 1'b0;
                  rcv_tx       = 1'b1;
                  rcv_byte_tmr = 0;
                  rcv_state    = ST_DATA;
               end else if (b == CH_CMD_STOP) begin
                  rcv_start    = 1'b0;
                  rcv_stop     = 1'b1;
                  rcv_tx       = 1'b0;
                  rcv_byte_tmr = 0;
                  rcv_state    = ST_WAIT_END;
               end else begin
                  to_error();
               end
            end
            ST_DATA: begin
               if (is_digit) begin
                  // digits past the store are taken but dropped
                  rcv_byte_tmr = 0;
                  if (rcv_field < DIGIT_DEPTH) begin
                     rcv_digits[rcv_field] = 4'(b - CH_ZERO);
                     rcv_field++;
                  end
               end else if (b == CH_DATA_END) begin
                  rcv_byte_tmr = 0;
                  rcv_field    = 0;
                  rcv_state    = ST_NAME;
               end else begin
                  to_error();
               end
            end
            ST_NAME: begin
               if (is_letter) begin
                  rcv_byte_tmr = 0;
                  if (rcv_field < NAME_DEPTH - 1) rcv_field++;
               end else if (b == CH_NAME_END) begin
                  // terminator always fits, so the length tops out at the depth
                  rcv_byte_tmr = 0;
                  if (rcv_field > NAME_DEPTH - 1) rcv_field = NAME_DEPTH - 1;
                  rcv_name_len = rcv_field + 1;
                  rcv_field    = 0;
                  rcv_state    = ST_WAIT_END;
               end else begin
                  to_error();
               end
            end
            ST_WAIT_END: begin
               if (b == cfg_close_byte) begin
                  if (rcv_start) begin
                     rcv_running = 1'b1;
                     rcv_stop    = 1'b0;
                  end else if (rcv_stop) begin
                     rcv_running = 1'b0;
                     rcv_start   = 1'b0;
                  end
                  rcv_state = ST_WAIT_START;
               end else begin
                  to_error();
               end
            end
            default: ;   // bytes in error are dropped
         endcase
      end
      s.rx_state      = rcv_state;
      s.running       = rcv_running;
      s.tx_enable     = rcv_tx;
      s.temp_min      = digit_pair(0);
      s.temp_max      = digit_pair(2);
      s.soil_humidity = digit_pair(4);
      s.air_humidity  = digit_pair(6);
      s.supply_code   = rcv_digits[8];
      s.name_length   = 5'(rcv_name_len);
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------------
   int fail_count = 0;

   task automatic note_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTED) $display("status mismatch: %s", msg);
   endtask

   task automatic check_field(input string field, input int seq,
                              input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         note_mismatch($sformatf("word %0d %s got %0h want %0h", seq, field, got, want));
   endtask

   // ------------------------------------------------------------------------
   // Stimulus plan: words, register writes and settle points, in order
   // ------------------------------------------------------------------------
   typedef enum {ACT_WORD, ACT_CSR, ACT_SETTLE} action_kind_type;

   typedef struct {
      action_kind_type kind;
      logic            op;
      logic [7:0]      rx_byte;
      reg_index_type   idx;
      logic [31:0]     value;
   } action_type;

   action_type frame_plan_q [$];
   status_type status_due_q [$];

   int         plan_words = 0;
   logic [7:0] plan_start;
   logic [7:0] plan_end;
   int         plan_rx;
   int         plan_err;
   bit         spoil_frame;

   task automatic add_word(input logic op, input logic [7:0] b);
      action_type a;
      a.kind    = ACT_WORD;
      a.op      = op;
      a.rx_byte = b;
      a.idx     = REG_START_CHAR;
      a.value   = '0;
      frame_plan_q.push_back(a);
      plan_words++;
   endtask

   task automatic add_tick(input int n);
      repeat (n) add_word(OP_TICK, 8'($urandom));   // byte lane is don't-care
   endtask

   // sender holds off until every status word due has come back
   task automatic add_settle();
      action_type a;
      a.kind    = ACT_SETTLE;
      a.op      = OP_BYTE;
      a.rx_byte = 8'h00;
      a.idx     = REG_START_CHAR;
      a.value   = '0;
      frame_plan_q.push_back(a);
   endtask

   task automatic add_setting(input logic [7:0] sc, input logic [7:0] ec,
                              input logic [15:0] rx, input logic [15:0] err);
      action_type a;
      logic [31:0] vals [4];
      vals = '{32'(sc), 32'(ec), 32'(rx), 32'(err)};
      add_settle();
      for (int i = 0; i < 4; i++) begin
         a.kind    = ACT_CSR;
         a.op      = OP_BYTE;
         a.rx_byte = 8'h00;
         a.idx     = reg_index_type'(i);
         a.value   = vals[i];
         frame_plan_q.push_back(a);
      end
      plan_start = sc;
      plan_end   = ec;
      plan_rx    = (rx == 0) ? 1 : rx;
      plan_err   = (err == 0) ? 1 : err;
   endtask

   // frame byte, now and then swapped for junk in a spoilt frame
   task automatic add_framed(input logic [7:0] b);
      if (spoil_frame && $urandom_range(0, 9) == 0) add_word(OP_BYTE, 8'($urandom));
      else add_word(OP_BYTE, b);
   endtask

   // occasional ticks between bytes; sometimes enough to trip the byte timeout
   task automatic add_idle_ticks();
      if ($urandom_range(0, 9) == 0)
         add_tick($urandom_range(1, (plan_rx < 16) ? plan_rx : 16));
   endtask

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(0, 51);
      if (r < 26) return 8'(CH_UPPER_A + r);
      return 8'(CH_LOWER_A + r - 26);
   endfunction

   task automatic add_frame();
      int         r;
      int         n;
      logic [7:0] cmd;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         // line noise
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1)) add_tick(1);
            else add_word(OP_BYTE, 8'($urandom));
         end
         return;
      end
      spoil_frame = ($urandom_range(0, 99) < 15);
      add_framed(plan_start);
      r = $urandom_range(0, 99);
      cmd = (r < 65) ? CH_CMD_START : (r < 92) ? CH_CMD_STOP : 8'($urandom);
      add_framed(cmd);
      if (cmd == CH_CMD_START) begin
         // mostly fits the digit store, some overlong
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
         repeat (n) begin
            add_idle_ticks();
            add_framed(8'(CH_ZERO + $urandom_range(0, 9)));
         end
         add_idle_ticks();
         add_framed(CH_DATA_END);
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 14);
         repeat (n) begin
            add_idle_ticks();
            add_framed(pick_letter());
         end
         add_idle_ticks();
         add_framed(CH_NAME_END);
      end
      add_framed(plan_end);
      // ticks to leave the error state, when there is one
      if (spoil_frame || $urandom_range(0, 3) == 0)
         add_tick(((plan_err < 24) ? plan_err : 24) + $urandom_range(0, 1));
      spoil_frame = 1'b0;
   endtask

   task automatic add_phase(input logic [7:0] sc, input logic [7:0] ec,
                            input logic [15:0] rx, input logic [15:0] err,
                            input int words);
      int goal;
      int half;
      add_setting(sc, ec, rx, err);
      goal = plan_words + words;
      half = plan_words + words / 2;
      while (plan_words < half) add_frame();
      add_settle();
      while (plan_words < goal) add_frame();
   endtask

   // ------------------------------------------------------------------------
   // Request driver and APB writer, fed from the plan
   // ------------------------------------------------------------------------
   int send_gap   = 0;
   int settle_cnt = 0;
   bit send_quiet = 1'b0;
   bit recv_quiet = 1'b0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   always @(posedge clock) begin : word_driver
      logic                  nv;
      logic                  nop;
      logic [7:0]            nbyte;
      logic                  npsel;
      logic                  npen;
      logic                  npw;
      logic [CSR_ADDR_W-1:0] naddr;
      logic [CSR_DATA_W-1:0] ndata;
      nv    = req_bus.valid;
      nop   = req_bus.op;
      nbyte = req_bus.rx_byte;
      npsel = psel;
      npen  = penable;
      npw   = pwrite;
      naddr = paddr;
      ndata = pwdata;
      if (reset) begin
         nv         = 1'b0;
         nop        = OP_BYTE;
         nbyte      = 8'h00;
         npsel      = 1'b0;
         npen       = 1'b0;
         npw        = 1'b0;
         naddr      = '0;
         ndata      = '0;
         send_gap   = 0;
         settle_cnt = 0;
      end else if (req_bus.valid && !req_bus.ready) begin
         // word still waiting: hold it
      end else if (psel && !penable) begin
         npen = 1'b1;                       // access phase
      end else if (psel) begin
         npsel = 1'b0;                      // register written at this edge
         npen  = 1'b0;
         npw   = 1'b0;
      end else begin
         nv = 1'b0;
         if (req_bus.valid)
            send_gap = (!send_quiet && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (frame_plan_q.size() != 0) begin
            case (frame_plan_q[0].kind)
               ACT_WORD: begin
                  nv    = 1'b1;
                  nop   = frame_plan_q[0].op;
                  nbyte = frame_plan_q[0].rx_byte;
                  void'(frame_plan_q.pop_front());
               end
               ACT_CSR: begin
                  npsel = 1'b1;
                  npw   = 1'b1;
                  naddr = CSR_ADDR_W'({frame_plan_q[0].idx, 2'b00});
                  ndata = frame_plan_q[0].value;
                  void'(frame_plan_q.pop_front());
               end
               default: begin
                  // settle only after empty cycles in a row, so a status word still
                  // being queued this edge is not missed
                  if (status_due_q.size() == 0) begin
                     settle_cnt++;
                     if (settle_cnt >= 3) begin
                        settle_cnt = 0;
                        void'(frame_plan_q.pop_front());
                     end
                  end else begin
                     settle_cnt = 0;
                  end
               end
            endcase
         end
      end
      req_bus.valid   <= nv;
      req_bus.op      <= nop;
      req_bus.rx_byte <= nbyte;
      psel            <= npsel;
      penable         <= npen;
      pwrite          <= npw;
      paddr           <= naddr;
      pwdata          <= ndata;
   end

   // ------------------------------------------------------------------------
   // Response back-pressure; quiet stretches on either side now and then
   // ------------------------------------------------------------------------
   int recv_stall = 0;

   always @(posedge clock) begin
      if ($urandom_range(0, 299) == 0) send_quiet <= !send_quiet;
      if ($urandom_range(0, 299) == 0) recv_quiet <= !recv_quiet;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b1;
         recv_stall = 0;
      end else if (recv_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         recv_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!recv_quiet && $urandom_range(0, 3) == 0) recv_stall = pick_gap();
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks status words, runs the model on accepted words, and
   // follows register writes
   // ------------------------------------------------------------------------
   int status_seen = 0;

   always @(posedge clock) begin : status_monitor
      status_type want;
      if (reset) begin
         reset_receiver();
         status_due_q.delete();
      end else begin
         // check before queueing: a word taken this edge cannot answer here
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (status_due_q.size() == 0) begin
               note_mismatch($sformatf("word %0d arrived with nothing due", status_seen));
            end else begin
               want = status_due_q.pop_front();
               check_field("rx_state", status_seen, 8'(rsp_bus.rx_state),
                           8'(want.rx_state));
               check_field("running", status_seen, 8'(rsp_bus.running),
                           8'(want.running));
               check_field("tx_enable", status_seen, 8'(rsp_bus.tx_enable),
                           8'(want.tx_enable));
               check_field("temp_min", status_seen, 8'(rsp_bus.temp_min),
                           8'(want.temp_min));
               check_field("temp_max", status_seen, 8'(rsp_bus.temp_max),
                           8'(want.temp_max));
               check_field("soil_humidity", status_seen, 8'(rsp_bus.soil_humidity),
                           8'(want.soil_humidity));
               check_field("air_humidity", status_seen, 8'(rsp_bus.air_humidity),
                           8'(want.air_humidity));
               check_field("supply_code", status_seen, 8'(rsp_bus.supply_code),
                           8'(want.supply_code));
               check_field("name_length", status_seen, 8'(rsp_bus.name_length),
                           8'(want.name_length));
            end
            status_seen++;
         end
         if (req_bus.valid && req_bus.ready)
            status_due_q.push_back(step_receiver(req_bus.op, req_bus.rx_byte));
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_START_CHAR:  cfg_open_byte  = pwdata[7:0];
               REG_END_CHAR:    cfg_close_byte = pwdata[7:0];
               REG_RX_TIMEOUT:  cfg_rx_ticks   = pwdata[15:0];
               REG_ERR_TIMEOUT: cfg_err_ticks  = pwdata[15:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long without any handshake means the block is stuck
   // ------------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Plan and end of run
   // ------------------------------------------------------------------------
   initial begin
      spoil_frame = 1'b0;

      // directed: short timeouts so error exits stay cheap
      add_setting(8'h24, 8'h23, 16'd3, 16'd2);
      add_tick(1);                                   // tick while waiting: no effect
      add_word(OP_BYTE, 8'h24);
      add_word(OP_BYTE, CH_CMD_START);
      add_word(OP_BYTE, CH_NINE);
      add_word(OP_BYTE, CH_NINE);
      add_word(OP_BYTE, CH_ZERO);
      add_word(OP_BYTE, CH_ZERO);
      add_word(OP_BYTE, CH_NINE);                    // short field, rest kept
      add_word(OP_BYTE, CH_DATA_END);
      add_word(OP_BYTE, CH_UPPER_A);
      add_word(OP_BYTE, CH_LOWER_Z);
      add_word(OP_BYTE, CH_UPPER_Z);
      add_word(OP_BYTE, CH_LOWER_A);
      add_word(OP_BYTE, CH_NAME_END);
      add_word(OP_BYTE, 8'h23);                      // start frame done: running
      add_word(OP_BYTE, 8'h24);
      add_word(OP_BYTE, CH_CMD_STOP);
      add_word(OP_BYTE, 8'h23);                      // stop frame done
      add_word(OP_BYTE, 8'hFF);                      // junk at frame start
      add_word(OP_BYTE, 8'h00);                      // ignored in error
      add_tick(2);                                   // error timeout
      add_word(OP_BYTE, 8'h24);
      add_word(OP_BYTE, CH_CMD_START);
      add_tick(3);                                   // byte timeout in data
      add_tick(2);

      // random phases, extremes of every register among them
      add_phase(8'h24, 8'h23, 16'd8, 16'd4, 150);
      add_phase(8'h00, 8'hFF, 16'd1, 16'd1, 150);
      add_phase(8'hFF, 8'h00, 16'd0, 16'd0, 150);    // zero timeouts act as one
      add_phase(8'($urandom), 8'($urandom), 16'd65535, 16'd3, 100);
      add_phase(8'h24, 8'h23, 16'd6, 16'd65535, 60);
      add_phase(8'($urandom), 8'($urandom), 16'($urandom_range(2, 20)),
                16'($urandom_range(1, 10)), 200);
      add_phase(8'h24, 8'h23, 16'($urandom_range(2, 20)),
                16'($urandom_range(1, 10)), 200);

      // everything sent and answered, then idle before the verdict
      do @(negedge clock);
      while (frame_plan_q.size() != 0 || req_bus.valid || status_due_q.size() != 0);
      repeat (6) @(negedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- command_frame_receiver.f -----
src/cfr_pkg.sv
src/cfr_req_if.sv
src/cfr_rsp_if.sv
src/cfr_csr.sv
src/cfr_core.sv
src/command_frame_receiver.sv
tb/tb.sv
